@@ rtl/s2wcc_pkg.sv @@
// ============================================================================
// s2wcc_pkg: shared types and constants for the sliding 2D window cell cache
// Holds the window size limits, the register indexes, the slide step codes
// and the command/status records between controller and datapath.
// ============================================================================
package s2wcc_pkg;

    // Window size limits.
    localparam int MAX_COLS = 16;
    localparam int MAX_ROWS = 16;

    // Index widths for slot columns and rows, and count widths for sizes.
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WCNT_W = $clog2(MAX_COLS + 1);
    localparam int HCNT_W = $clog2(MAX_ROWS + 1);

    // Field widths.
    localparam int POS_W = 16;
    localparam int SLOT_W = 8;
    localparam int CFG_W = 5;
    localparam int CFG_IDX_W = 1;
    // Coordinate compares need room above the 16-bit range.
    localparam int CMP_W = POS_W + 2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 1'd1;

    // Input kinds.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Window slide step codes.
    localparam logic [2:0] STEP_NONE = 3'd0;
    localparam logic [2:0] STEP_LEFT = 3'd1;
    localparam logic [2:0] STEP_RIGHT = 3'd2;
    localparam logic [2:0] STEP_UP = 3'd3;
    localparam logic [2:0] STEP_DOWN = 3'd4;

    // Controller to datapath commands.
    typedef struct packed {
        logic       load_req;
        logic       clear_all;
        logic       reanchor;
        logic [2:0] step;
        logic       lookup;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic       kind;
        logic       far;
        logic [2:0] step;
        logic       out_free;
    } t_status;

    // Effective column count: zero acts as one, large values saturate.
    function automatic logic [WCNT_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        logic [WCNT_W-1:0] res;
        if (v == '0) begin
            res = WCNT_W'(1);
        end else if (int'(v) > MAX_COLS) begin
            res = WCNT_W'(MAX_COLS);
        end else begin
            res = WCNT_W'(v);
        end
        return res;
    endfunction

    // Effective row count: zero acts as one, large values saturate.
    function automatic logic [HCNT_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        logic [HCNT_W-1:0] res;
        if (v == '0) begin
            res = HCNT_W'(1);
        end else if (int'(v) > MAX_ROWS) begin
            res = HCNT_W'(MAX_ROWS);
        end else begin
            res = HCNT_W'(v);
        end
        return res;
    endfunction

endpackage

@@ rtl/s2wcc_dpath.sv @@
// ============================================================================
// s2wcc_dpath: window state, valid flags and result register
// Holds the request, the window origin and its wrapped origin slot, the
// per-slot valid flags and the output word. Carries out one command a cycle.
// ============================================================================
module s2wcc_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [s2wcc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [s2wcc_pkg::CFG_W-1:0]       i_cfg_data,
    // Request payload
    input  logic                              i_kind,
    input  logic [s2wcc_pkg::POS_W-1:0]       i_pos_x,
    input  logic [s2wcc_pkg::POS_W-1:0]       i_pos_y,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [s2wcc_pkg::SLOT_W-1:0]      o_slot_index,
    output logic                              o_needs_build,
    // Controller link
    input  s2wcc_pkg::t_cmd                   i_cmd,
    output s2wcc_pkg::t_status                o_st
);

    localparam int CW = s2wcc_pkg::CMP_W;
    localparam int PROD_W = s2wcc_pkg::ROW_W + s2wcc_pkg::WCNT_W + 1;

    // Request registers.
    logic                              r_kind;
    logic [s2wcc_pkg::POS_W-1:0]       r_px;
    logic [s2wcc_pkg::POS_W-1:0]       r_py;

    // Window state.
    logic [s2wcc_pkg::WCNT_W-1:0]      r_w;
    logic [s2wcc_pkg::HCNT_W-1:0]      r_h;
    logic [s2wcc_pkg::POS_W-1:0]       r_ox;
    logic [s2wcc_pkg::POS_W-1:0]       r_oy;
    logic [s2wcc_pkg::COL_W-1:0]       r_org_col;
    logic [s2wcc_pkg::ROW_W-1:0]       r_org_row;
    logic [s2wcc_pkg::MAX_COLS-1:0]    r_flag [s2wcc_pkg::MAX_ROWS];

    // Output word.
    logic                              r_out_valid;
    logic [s2wcc_pkg::SLOT_W-1:0]      r_slot;
    logic                              r_build;

    // Combinational helpers.
    logic [CW-1:0]                     pxe, pye, oxe, oye, we, he;
    logic                              left, right, up, down, far;
    logic [s2wcc_pkg::COL_W-1:0]       prev_col, next_col;
    logic [s2wcc_pkg::ROW_W-1:0]       prev_row, next_row;
    logic [s2wcc_pkg::WCNT_W:0]        cx_sum;
    logic [s2wcc_pkg::HCNT_W:0]        cy_sum;
    logic [s2wcc_pkg::COL_W-1:0]       cx;
    logic [s2wcc_pkg::ROW_W-1:0]       cy;
    logic [PROD_W-1:0]                 slot_full;
    logic                              cfg_hit;
    logic                              wipe;

    // Position of the request against the window, on widened values.
    always_comb begin
        pxe = CW'(r_px);
        pye = CW'(r_py);
        oxe = CW'(r_ox);
        oye = CW'(r_oy);
        we  = CW'(r_w);
        he  = CW'(r_h);
        left  = pxe < oxe;
        right = pxe >= oxe + we;
        up    = pye < oye;
        down  = pye >= oye + he;
        far   = (pxe + we - CW'(1) < oxe) || (pxe >= oxe + (we << 1) - CW'(1)) ||
                (pye + he - CW'(1) < oye) || (pye >= oye + (he << 1) - CW'(1));
    end

    // Status to the controller; horizontal steps go before vertical ones.
    always_comb begin
        o_st.kind = r_kind;
        o_st.far = far;
        o_st.out_free = !r_out_valid || i_out_ready;
        if (left) begin
            o_st.step = s2wcc_pkg::STEP_LEFT;
        end else if (right) begin
            o_st.step = s2wcc_pkg::STEP_RIGHT;
        end else if (up) begin
            o_st.step = s2wcc_pkg::STEP_UP;
        end else if (down) begin
            o_st.step = s2wcc_pkg::STEP_DOWN;
        end else begin
            o_st.step = s2wcc_pkg::STEP_NONE;
        end
    end

    // Wrapped neighbors of the origin slot.
    always_comb begin
        prev_col = (r_org_col == '0) ? s2wcc_pkg::COL_W'(r_w - 1'b1)
                                     : r_org_col - 1'b1;
        next_col = (s2wcc_pkg::WCNT_W'(r_org_col) == r_w - 1'b1) ? '0
                                     : r_org_col + 1'b1;
        prev_row = (r_org_row == '0) ? s2wcc_pkg::ROW_W'(r_h - 1'b1)
                                     : r_org_row - 1'b1;
        next_row = (s2wcc_pkg::HCNT_W'(r_org_row) == r_h - 1'b1) ? '0
                                     : r_org_row + 1'b1;
    end

    // Slot of the request inside the window, wrapped around the origin slot.
    always_comb begin
        cx_sum = (s2wcc_pkg::WCNT_W + 1)'(r_px - r_ox) + (s2wcc_pkg::WCNT_W + 1)'(r_org_col);
        if (cx_sum >= (s2wcc_pkg::WCNT_W + 1)'(r_w)) begin
            cx_sum = cx_sum - (s2wcc_pkg::WCNT_W + 1)'(r_w);
        end
        cy_sum = (s2wcc_pkg::HCNT_W + 1)'(r_py - r_oy) + (s2wcc_pkg::HCNT_W + 1)'(r_org_row);
        if (cy_sum >= (s2wcc_pkg::HCNT_W + 1)'(r_h)) begin
            cy_sum = cy_sum - (s2wcc_pkg::HCNT_W + 1)'(r_h);
        end
        cx = s2wcc_pkg::COL_W'(cx_sum);
        cy = s2wcc_pkg::ROW_W'(cy_sum);
        slot_full = PROD_W'(cy) * PROD_W'(r_w) + PROD_W'(cx);
    end

    // A register write or a clear wipes the window.
    always_comb begin
        cfg_hit = 1'b0;
        case (i_cfg_idx)
            s2wcc_pkg::CFG_WINDOW_WIDTH:  cfg_hit = i_cfg_we;
            s2wcc_pkg::CFG_WINDOW_HEIGHT: cfg_hit = i_cfg_we;
            default:                      cfg_hit = 1'b0;
        endcase
        wipe = cfg_hit || i_cmd.clear_all;
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_kind <= i_kind;
            r_px <= i_pos_x;
            r_py <= i_pos_y;
        end
    end

    // Window sizes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= s2wcc_pkg::clamp_cols(s2wcc_pkg::CFG_W'(16));
            r_h <= s2wcc_pkg::clamp_rows(s2wcc_pkg::CFG_W'(16));
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                s2wcc_pkg::CFG_WINDOW_WIDTH:  r_w <= s2wcc_pkg::clamp_cols(i_cfg_data);
                s2wcc_pkg::CFG_WINDOW_HEIGHT: r_h <= s2wcc_pkg::clamp_rows(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Origin and origin slot: wiped, re-anchored or moved one step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || wipe) begin
            r_ox <= '0;
            r_oy <= '0;
            r_org_col <= '0;
            r_org_row <= '0;
        end else if (i_cmd.reanchor) begin
            r_ox <= r_px;
            r_oy <= r_py;
            r_org_col <= '0;
            r_org_row <= '0;
        end else begin
            case (i_cmd.step)
                s2wcc_pkg::STEP_LEFT: begin
                    r_ox <= r_ox - 1'b1;
                    r_org_col <= prev_col;
                end
                s2wcc_pkg::STEP_RIGHT: begin
                    r_ox <= r_ox + 1'b1;
                    r_org_col <= next_col;
                end
                s2wcc_pkg::STEP_UP: begin
                    r_oy <= r_oy - 1'b1;
                    r_org_row <= prev_row;
                end
                s2wcc_pkg::STEP_DOWN: begin
                    r_oy <= r_oy + 1'b1;
                    r_org_row <= next_row;
                end
                default: ;
            endcase
        end
    end

    // Valid flags: a step clears the vacated column or row, a lookup sets one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || wipe || i_cmd.reanchor) begin
            for (int r = 0; r < s2wcc_pkg::MAX_ROWS; r++) begin
                r_flag[r] <= '0;
            end
        end else begin
            case (i_cmd.step)
                s2wcc_pkg::STEP_LEFT: begin
                    for (int r = 0; r < s2wcc_pkg::MAX_ROWS; r++) begin
                        r_flag[r][prev_col] <= 1'b0;
                    end
                end
                s2wcc_pkg::STEP_RIGHT: begin
                    for (int r = 0; r < s2wcc_pkg::MAX_ROWS; r++) begin
                        r_flag[r][r_org_col] <= 1'b0;
                    end
                end
                s2wcc_pkg::STEP_UP:   r_flag[prev_row] <= '0;
                s2wcc_pkg::STEP_DOWN: r_flag[r_org_row] <= '0;
                default: begin
                    if (i_cmd.lookup && (r_kind == s2wcc_pkg::KIND_REQUEST)) begin
                        r_flag[cy][cx] <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Output word valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.lookup) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload; a clear item gives slot zero and no build.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            if (r_kind == s2wcc_pkg::KIND_CLEAR) begin
                r_slot <= '0;
                r_build <= 1'b0;
            end else begin
                r_slot <= s2wcc_pkg::SLOT_W'(slot_full);
                r_build <= !r_flag[cy][cx];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_slot_index = r_slot;
    assign o_needs_build = r_build;

    // The origin slot always lies inside the configured window.
    a_col_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2wcc_pkg::WCNT_W'(r_org_col) < r_w)
        else $error("origin slot column outside window");

    a_row_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2wcc_pkg::HCNT_W'(r_org_row) < r_h)
        else $error("origin slot row outside window");

    // A looked-up request slot is valid right after the lookup.
    a_flag_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.lookup && r_kind == s2wcc_pkg::KIND_REQUEST && !i_cfg_we)
        |=> r_flag[$past(cy)][$past(cx)])
        else $error("slot flag not set after lookup");

endmodule

@@ rtl/s2wcc_ctrl.sv @@
// ============================================================================
// s2wcc_ctrl: request sequencer
// Takes one word at a time, decides between clear, re-anchor and slide,
// walks the window one step a cycle, then issues the slot lookup.
// ============================================================================
module s2wcc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  s2wcc_pkg::t_status  i_st,
    output s2wcc_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SLIDE = 2'd2;
    localparam logic [1:0] S_LOOK  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.step = s2wcc_pkg::STEP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_st.kind == s2wcc_pkg::KIND_CLEAR) begin
                    o_cmd.clear_all = 1'b1;
                    n_state = S_LOOK;
                end else if (i_st.far) begin
                    o_cmd.reanchor = 1'b1;
                    n_state = S_LOOK;
                end else if (i_st.step == s2wcc_pkg::STEP_NONE) begin
                    n_state = S_LOOK;
                end else begin
                    n_state = S_SLIDE;
                end
            end
            S_SLIDE: begin
                o_cmd.step = i_st.step;
                if (i_st.step == s2wcc_pkg::STEP_NONE) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_st.out_free) begin
                    o_cmd.lookup = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted word always moves on to classification.
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == S_CHECK)
        else $error("accepted word did not reach classification");

    // A lookup is only issued when the output register can take it.
    a_lookup_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.lookup |-> i_st.out_free)
        else $error("lookup issued into a full output register");

    // Sliding ends in the lookup state once the request is inside.
    a_slide_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLIDE && i_st.step == s2wcc_pkg::STEP_NONE) |=> r_state == S_LOOK)
        else $error("slide did not end in lookup");

endmodule

@@ rtl/sliding_2d_window_cell_cache_core.sv @@
// ============================================================================
// sliding_2d_window_cell_cache_core: toroidal window cell cache, valid flags
// Maps a requested cell to its wrapped slot, sliding or re-anchoring the
// window as needed, and reports whether the slot must be built.
//
//   Channel   Direction  Handshake                   Word
//   request   in         i_in_valid / o_in_ready     i_kind, i_pos_x, i_pos_y
//   result    out        o_out_valid / i_out_ready   o_slot_index, o_needs_build
//   config    in         i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
// A request inside the window goes from accept through check to lookup. A
// request that slides also walks the slide state, one window slide step per
// cycle (up to width-1 + height-1 steps), clearing one column or row of flags
// per step, until it is inside. Clear items and far requests skip the slide.
// Reset (synchronous, active low) clears all flags and the origin at once
// and sets both sizes to 16. A stalled result holds in the output register;
// the next word is taken meanwhile and waits in lookup until it drains.
// ============================================================================
module sliding_2d_window_cell_cache_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [s2wcc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [s2wcc_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_kind,
    input  logic [s2wcc_pkg::POS_W-1:0]       i_pos_x,
    input  logic [s2wcc_pkg::POS_W-1:0]       i_pos_y,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [s2wcc_pkg::SLOT_W-1:0]      o_slot_index,
    output logic                              o_needs_build
);

    s2wcc_pkg::t_cmd    cmd;
    s2wcc_pkg::t_status st;

    // Sequencer.
    s2wcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // Window state and flags.
    s2wcc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_slot_index  (o_slot_index),
        .o_needs_build (o_needs_build),
        .i_cmd         (cmd),
        .o_st          (st)
    );

endmodule

@@ dv/sliding_2d_window_cell_cache_core_checker.sv @@
// ============================================================================
// sliding_2d_window_cell_cache_core_checker: result predictor and comparator
// Watches the request, result and register write ports of the window cache.
// It keeps its own copy of the window origin, the wrapped origin slot and the
// per-slot valid flags, and works out the slot and build flag for every
// accepted request word. Each accepted result word is checked against the
// oldest prediction. Ports are sampled on the falling edge, where they are
// stable ahead of the rising edge that completes each transfer.
// ============================================================================
module sliding_2d_window_cell_cache_core_checker
    import s2wcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_kind,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [SLOT_W-1:0]    i_slot_index,
    input  logic                 i_needs_build,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic              needs_build;
    } t_slot_result;

    // Predicted result words, oldest first.
    t_slot_result expected_slots[$];

    // Window geometry and cache state as the block should hold them.
    int                           win_cols = MAX_COLS;
    int                           win_rows = MAX_ROWS;
    int                           org_x = 0;
    int                           org_y = 0;
    int                           org_col = 0;
    int                           org_row = 0;
    logic [MAX_COLS*MAX_ROWS-1:0] slot_built = '0;
    int                           fail_count = 0;
    int                           pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending = pending_count;

    // Effective size of a register value: zero acts as one, large values saturate.
    function automatic int window_size(input logic [CFG_W-1:0] v, input int limit);
        int n;
        n = int'(v);
        if (n == 0) begin
            n = 1;
        end else if (n > limit) begin
            n = limit;
        end
        return n;
    endfunction

    // Drop every flag and put the window back at the origin.
    task automatic flush_window();
        slot_built = '0;
        org_x = 0;
        org_y = 0;
        org_col = 0;
        org_row = 0;
    endtask

    task automatic drop_column(input int c);
        for (int r = 0; r < win_rows; r++) begin
            slot_built[r*win_cols + c] = 1'b0;
        end
    endtask

    task automatic drop_row(input int r);
        for (int c = 0; c < win_cols; c++) begin
            slot_built[r*win_cols + c] = 1'b0;
        end
    endtask

    // Work out the result word for one request word and update the cache state.
    task automatic locate_slot(input logic kind, input logic [POS_W-1:0] x_in,
                               input logic [POS_W-1:0] y_in, output t_slot_result res);
        int px;
        int py;
        int cx;
        int cy;
        int slot;
        px = int'(x_in);
        py = int'(y_in);
        res = '0;
        if (kind == KIND_CLEAR) begin
            flush_window();
        end else begin
            if (px < org_x || px >= org_x + win_cols ||
                py < org_y || py >= org_y + win_rows) begin
                if (px < org_x - (win_cols - 1) || px >= org_x + 2*win_cols - 1 ||
                    py < org_y - (win_rows - 1) || py >= org_y + 2*win_rows - 1) begin
                    // Too far to slide: start over with the word at the top-left.
                    slot_built = '0;
                    org_x = px;
                    org_y = py;
                    org_col = 0;
                    org_row = 0;
                end else begin
                    // Slide one column or row at a time, dropping what is vacated.
                    while (px < org_x) begin
                        org_col = (org_col + win_cols - 1) % win_cols;
                        drop_column(org_col);
                        org_x--;
                    end
                    while (px >= org_x + win_cols) begin
                        drop_column(org_col);
                        org_x++;
                        org_col = (org_col + 1) % win_cols;
                    end
                    while (py < org_y) begin
                        org_row = (org_row + win_rows - 1) % win_rows;
                        drop_row(org_row);
                        org_y--;
                    end
                    while (py >= org_y + win_rows) begin
                        drop_row(org_row);
                        org_y++;
                        org_row = (org_row + 1) % win_rows;
                    end
                end
            end
            cx = px - org_x + org_col;
            if (cx >= win_cols) begin
                cx -= win_cols;
            end
            cy = py - org_y + org_row;
            if (cy >= win_rows) begin
                cy -= win_rows;
            end
            slot = cy*win_cols + cx;
            res.slot_index = SLOT_W'(slot);
            res.needs_build = !slot_built[slot];
            slot_built[slot] = 1'b1;
        end
    endtask

    // Follow reset, register writes and both channels once per cycle.
    always @(negedge i_clk) begin
        t_slot_result got;
        t_slot_result want;
        if (!i_rst_n) begin
            win_cols = MAX_COLS;
            win_rows = MAX_ROWS;
            flush_window();
            expected_slots.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_WIDTH: win_cols = window_size(i_cfg_data, MAX_COLS);
                    CFG_WINDOW_HEIGHT: win_rows = window_size(i_cfg_data, MAX_ROWS);
                    default: ;
                endcase
                flush_window();
            end
            // The result word leaving now always belongs to an older request.
            if (i_out_valid && i_out_ready) begin
                got.slot_index = i_slot_index;
                got.needs_build = i_needs_build;
                if (expected_slots.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual slot %0d build %0b",
                             $time, got.slot_index, got.needs_build);
                    fail_count++;
                end else begin
                    want = expected_slots.pop_front();
                    if (got.slot_index !== want.slot_index) begin
                        $display("%0t: slot_index mismatch, expected %0d, actual %0d",
                                 $time, want.slot_index, got.slot_index);
                        fail_count++;
                    end
                    if (got.needs_build !== want.needs_build) begin
                        $display("%0t: needs_build mismatch, expected %0b, actual %0b",
                                 $time, want.needs_build, got.needs_build);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                locate_slot(i_kind, i_pos_x, i_pos_y, want);
                expected_slots.push_back(want);
            end
        end
        pending_count = expected_slots.size();
    end

endmodule

@@ dv/sliding_2d_window_cell_cache_core_tb.sv @@
// ============================================================================
// sliding_2d_window_cell_cache_core_tb: stimulus and verdict for the cache
// Runs a directed set of window hits, single-step and long slides in every
// direction, far jumps and clear words, then random walks of requests over
// several window sizes, zero and saturating sizes among them. Both channels
// idle at random, and the result side once holds off long enough to back up
// the block. A separate checker predicts and compares every result word.
// ============================================================================
module sliding_2d_window_cell_cache_core_tb;

    import s2wcc_pkg::*;

    localparam int CLK_HALF = 10;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_WORDS = 112;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 50;
    localparam int PHASE_COUNT = 7;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 kind = KIND_REQUEST;
    logic [POS_W-1:0]     pos_x = '0;
    logic [POS_W-1:0]     pos_y = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [SLOT_W-1:0]    slot_index;
    logic                 needs_build;

    int fail_count;
    int pending;
    int cycle_count;

    // Idle controls shared by the sender, the receiver and the main sequence.
    bit tx_gaps = 1'b0;
    bit rx_stalls = 1'b0;
    bit hold_off_req = 1'b0;

    // Size the stimulus walks with and the last requested position.
    int win_cols = MAX_COLS;
    int win_rows = MAX_ROWS;
    int cur_x = 0;
    int cur_y = 0;

    // Window sizes written per random phase, extremes first.
    logic [CFG_W-1:0] width_list [PHASE_COUNT] =
        '{5'd0, 5'd31, 5'd1, 5'd16, 5'd3, 5'd17, 5'd7};
    logic [CFG_W-1:0] height_list [PHASE_COUNT] =
        '{5'd0, 5'd31, 5'd16, 5'd1, 5'd5, 5'd2, 5'd12};

    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    sliding_2d_window_cell_cache_core uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_kind        (kind),
        .i_pos_x       (pos_x),
        .i_pos_y       (pos_y),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_slot_index  (slot_index),
        .o_needs_build (needs_build)
    );

    sliding_2d_window_cell_cache_core_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_kind        (kind),
        .i_pos_x       (pos_x),
        .i_pos_y       (pos_y),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_slot_index  (slot_index),
        .i_needs_build (needs_build),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Offer one request word, after an optional short gap, and wait until it is taken.
    task automatic send_word(input logic k, input int x, input int y);
        bit taken;
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        pos_x <= POS_W'(x);
        pos_y <= POS_W'(y);
        do begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end while (!taken);
    endtask

    // Stop offering and wait until every result word has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both size registers on back-to-back cycles while the block is idle.
    task automatic set_window(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_WINDOW_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_idx <= CFG_WINDOW_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        win_cols = (w == '0) ? 1 : ((int'(w) > MAX_COLS) ? MAX_COLS : int'(w));
        win_rows = (h == '0) ? 1 : ((int'(h) > MAX_ROWS) ? MAX_ROWS : int'(h));
        cur_x = 0;
        cur_y = 0;
    endtask

    // Move a coordinate by up to span either way, kept inside the 16-bit range.
    function automatic int nudge(input int v, input int span);
        int n;
        n = v + int'($urandom_range(0, 2*span)) - span;
        if (n < 0) begin
            n = 0;
        end else if (n > 65535) begin
            n = 65535;
        end
        return n;
    endfunction

    // Mostly a random walk near the last request, with far jumps, edge jumps and clears.
    task automatic random_word();
        int roll;
        int span;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            send_word(KIND_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535));
            cur_x = 0;
            cur_y = 0;
        end else begin
            if (roll < 9) begin
                cur_x = $urandom_range(0, 65535);
                cur_y = $urandom_range(0, 65535);
            end else if (roll < 13) begin
                cur_x = $urandom_range(0, 1) ? 65535 - int'($urandom_range(0, 2*win_cols))
                                             : int'($urandom_range(0, 2*win_cols));
                cur_y = $urandom_range(0, 1) ? 65535 - int'($urandom_range(0, 2*win_rows))
                                             : int'($urandom_range(0, 2*win_rows));
            end else begin
                span = (roll < 55) ? 2 : win_cols;
                cur_x = nudge(cur_x, span);
                span = (roll < 55) ? 2 : win_rows;
                cur_y = nudge(cur_y, span);
            end
            send_word(KIND_REQUEST, cur_x, cur_y);
        end
    endtask

    // Result side: random short stalls, and one long hold-off on request.
    initial begin
        int stall;
        @(posedge clk);
        forever begin
            if (hold_off_req) begin
                out_ready <= 1'b0;
                stall = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                stall = $urandom_range(1, 3);
            end else begin
                out_ready <= 1'b1;
                stall = 1;
            end
            repeat (stall) @(posedge clk);
        end
    end

    // Give up if the run hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Main sequence: reset, directed words, then one random phase per window size.
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;

        // Hits, single steps each way, long slides, far jumps and clears at 16x16.
        send_word(KIND_REQUEST, 0, 0);
        send_word(KIND_REQUEST, 0, 0);
        send_word(KIND_REQUEST, 15, 15);
        send_word(KIND_REQUEST, 16, 0);
        send_word(KIND_REQUEST, 0, 0);
        send_word(KIND_REQUEST, 0, 16);
        send_word(KIND_REQUEST, 0, 0);
        send_word(KIND_REQUEST, 30, 0);
        send_word(KIND_REQUEST, 0, 30);
        send_word(KIND_REQUEST, 65535, 65535);
        send_word(KIND_REQUEST, 65520, 65520);
        send_word(KIND_REQUEST, 65535, 65535);
        send_word(KIND_REQUEST, 16'h5555, 16'hAAAA);
        send_word(KIND_REQUEST, 16'hAAAA, 16'h5555);
        send_word(KIND_CLEAR, 65535, 65535);
        send_word(KIND_REQUEST, 0, 0);
        // Just past the slide range, then far outside it on the low side.
        send_word(KIND_REQUEST, 31, 31);
        send_word(KIND_REQUEST, 1, 1);
        send_word(KIND_REQUEST, 17, 17);
        send_word(KIND_CLEAR, 0, 0);
        send_word(KIND_REQUEST, 16, 16);
        settle();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            set_window(width_list[phase], height_list[phase]);
            if (phase == 1) begin
                hold_off_req = 1'b1;
            end
            if (phase == PHASE_COUNT - 1) begin
                tx_gaps = 1'b0;
                rx_stalls = 1'b0;
            end
            repeat (PHASE_WORDS) random_word();
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
